FILE: sv/pstl_pkg.sv
// Shared types and constants for the priority-sorted task list.
// Holds command and status codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package pstl_pkg;

	// Field widths fixed by the request and result formats
	localparam int ID_W  = 8;
	localparam int PRI_W = 8;
	localparam int CMD_W = 2;
	localparam int ST_W  = 2;
	localparam int POS_W = 6;

	// Request operation codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

	// Result status codes
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;    // latch request, compare against every cell
		logic apply;      // shift cells for insert/remove and load the result
		logic list_step;  // load the next listed entry into the result register
	} pstl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic empty;      // no entries held
		logic list_last;  // list pointer sits on the final entry
	} pstl_stat_t;

endpackage

`default_nettype wire

FILE: sv/priority_sorted_task_list.sv
// Priority-sorted task list: keeps up to DEPTH tasks ordered by descending
// priority, equal priorities in order of arrival.
// Request channel s_axis: tuser carries the operation (insert, remove, list),
// tdata the task identifier and priority. Result channel m_axis: tuser carries
// the status, tdata the identifier, priority and position, tlast marks the
// final result of a request.
// For insert and remove, the request edge compares it against every cell at
// once; the apply step then shifts the cell chain and loads the result
// register. A list request is captured first, then each listed entry passes
// in turn through the single result register (a single empty-status result
// when the list is empty).
// A request is taken only while no earlier request is still in progress; a
// result waiting in the output register does not block the next request.
// When the receiver stalls, the result register holds and the block waits
// with the next shift or list step until it is taken.
// Reset empties the list at once; no clearing pass is needed.
// Depends on pstl_pkg, pstl_ctrl and pstl_datapath.
`default_nettype none

module priority_sorted_task_list #(
	parameter int DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,   // [7:0] task_id, [15:8] priority_req
	input  wire  [1:0]  s_axis_tuser,   // [1:0] cmd
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] out_id, [15:8] out_priority,
	                                    // [21:16] position, [23:22] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	output logic        m_axis_tlast
);
	import pstl_pkg::*;

	pstl_cmd_t         cmd;
	pstl_stat_t        stat;
	logic [ID_W-1:0]   res_id;
	logic [PRI_W-1:0]  res_pri;
	logic [POS_W-1:0]  res_pos;

	pstl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	pstl_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_cmd     (s_axis_tuser),
		.in_id      (s_axis_tdata[7:0]),
		.in_pri     (s_axis_tdata[15:8]),
		.res_status (m_axis_tuser),
		.res_id     (res_id),
		.res_pri    (res_pri),
		.res_pos    (res_pos),
		.res_last   (m_axis_tlast)
	);

	// Pack the result fields, lowest first
	assign m_axis_tdata = {2'b00, res_pos, res_pri, res_id};

endmodule

`default_nettype wire

FILE: sv/pstl_ctrl.sv
// Controller state machine of the priority-sorted task list.
// Runs the request handshake and the result valid flag; drives the datapath.
// Depends on pstl_pkg.
`default_nettype none

module pstl_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire [pstl_pkg::CMD_W-1:0] in_cmd,
	output logic                   out_valid,
	input  wire                    out_ready,
	output pstl_pkg::pstl_cmd_t    cmd,
	input  pstl_pkg::pstl_stat_t   stat
);
	import pstl_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_APPLY = 2'd1;
	localparam logic [1:0] S_LIST  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       valid_q;
	logic       out_free;
	logic       accept;

	assign out_free  = !valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = valid_q;

	// Decode next state and datapath commands
	always_comb begin
		state_d        = state_q;
		cmd.capture    = 1'b0;
		cmd.apply      = 1'b0;
		cmd.list_step  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					if (in_cmd == CMD_INSERT || in_cmd == CMD_REMOVE) begin
						state_d = S_APPLY;
					end else if (in_cmd == CMD_LIST) begin
						state_d = S_LIST;
					end
				end
			end
			S_APPLY: begin
				if (out_free) begin
					cmd.apply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_LIST: begin
				if (out_free) begin
					cmd.list_step = 1'b1;
					if (stat.empty || stat.list_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold result valid until taken; set on every loaded result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.apply || cmd.list_step) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: sv/pstl_datapath.sv
// Datapath of the priority-sorted task list: the chain of entry cells,
// the per-cell compare masks, the list pointer and the result register.
// Depends on pstl_pkg.
`default_nettype none

module pstl_datapath #(
	parameter int DEPTH = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  pstl_pkg::pstl_cmd_t         cmd,
	output pstl_pkg::pstl_stat_t        stat,
	input  wire [pstl_pkg::CMD_W-1:0]   in_cmd,
	input  wire [pstl_pkg::ID_W-1:0]    in_id,
	input  wire [pstl_pkg::PRI_W-1:0]   in_pri,
	output logic [pstl_pkg::ST_W-1:0]   res_status,
	output logic [pstl_pkg::ID_W-1:0]   res_id,
	output logic [pstl_pkg::PRI_W-1:0]  res_pri,
	output logic [pstl_pkg::POS_W-1:0]  res_pos,
	output logic                        res_last
);
	import pstl_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Entry cells, ordered head first
	logic [ID_W-1:0]  id_q  [DEPTH];
	logic [PRI_W-1:0] pri_q [DEPTH];
	logic [ID_W-1:0]  id_d  [DEPTH];
	logic [PRI_W-1:0] pri_d [DEPTH];
	logic [CW-1:0]    count_q;

	// Captured request and compare masks
	logic [CMD_W-1:0] req_cmd_q;
	logic [ID_W-1:0]  req_id_q;
	logic [PRI_W-1:0] req_pri_q;
	logic [DEPTH-1:0] ge_q;
	logic [DEPTH-1:0] match_q;
	logic [DEPTH-1:0] ge_d;
	logic [DEPTH-1:0] match_d;

	logic [IW-1:0]    list_idx_q;
	logic [IW-1:0]    slot_ins;
	logic [IW-1:0]    slot_rm;
	logic             found;
	logic             full;
	logic             do_ins;
	logic             do_rm;

	assign full           = (count_q == CW'(DEPTH));
	assign found          = |match_q;
	assign do_ins         = cmd.apply && (req_cmd_q == CMD_INSERT) && !full;
	assign do_rm          = cmd.apply && (req_cmd_q == CMD_REMOVE) && found;
	assign stat.empty     = (count_q == '0);
	assign stat.list_last = ((CW'(list_idx_q) + CW'(1)) == count_q);

	// Compare the incoming request against every occupied cell
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ge_d[i]    = (CW'(i) < count_q) && (pri_q[i] >= in_pri);
			match_d[i] = (CW'(i) < count_q) && (id_q[i] == in_id);
		end
	end

	// Locate insert slot (first cell not ahead) and first matching cell
	always_comb begin
		slot_ins = '0;
		slot_rm  = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!ge_q[i]) begin
				slot_ins = IW'(i);
			end
			if (match_q[i]) begin
				slot_rm = IW'(i);
			end
		end
	end

	// Shift the cell chain: open a gap on insert, close it on remove
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			id_d[i]  = id_q[i];
			pri_d[i] = pri_q[i];
			if (do_ins) begin
				if (IW'(i) == slot_ins) begin
					id_d[i]  = req_id_q;
					pri_d[i] = req_pri_q;
				end else if (i > 0 && IW'(i) > slot_ins) begin
					id_d[i]  = id_q[(i > 0) ? i - 1 : 0];
					pri_d[i] = pri_q[(i > 0) ? i - 1 : 0];
				end
			end else if (do_rm) begin
				if (i < DEPTH - 1 && IW'(i) >= slot_rm) begin
					id_d[i]  = id_q[(i < DEPTH - 1) ? i + 1 : i];
					pri_d[i] = pri_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			id_q[i]  <= id_d[i];
			pri_q[i] <= pri_d[i];
		end
	end

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_ins) begin
			count_q <= count_q + CW'(1);
		end else if (do_rm) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Advance the list pointer, restart it on each new request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_idx_q <= '0;
		end else if (cmd.capture) begin
			list_idx_q <= '0;
		end else if (cmd.list_step && !stat.list_last && !stat.empty) begin
			list_idx_q <= list_idx_q + IW'(1);
		end
	end

	// Latch the request and its masks
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_cmd_q <= in_cmd;
			req_id_q  <= in_id;
			req_pri_q <= in_pri;
			ge_q      <= ge_d;
			match_q   <= match_d;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			res_last <= 1'b1;
			res_id   <= req_id_q;
			if (req_cmd_q == CMD_INSERT) begin
				res_status <= full ? ST_FULL : ST_OK;
				res_pri    <= req_pri_q;
				res_pos    <= full ? '0 : POS_W'(slot_ins);
			end else if (found) begin
				res_status <= ST_OK;
				res_pri    <= pri_q[slot_rm];
				res_pos    <= POS_W'(slot_rm);
			end else begin
				res_status <= ST_NOTFOUND;
				res_pri    <= '0;
				res_pos    <= '0;
			end
		end else if (cmd.list_step) begin
			if (stat.empty) begin
				res_status <= ST_EMPTY;
				res_id     <= '0;
				res_pri    <= '0;
				res_pos    <= '0;
				res_last   <= 1'b1;
			end else begin
				res_status <= ST_OK;
				res_id     <= id_q[list_idx_q];
				res_pri    <= pri_q[list_idx_q];
				res_pos    <= POS_W'(list_idx_q);
				res_last   <= stat.list_last;
			end
		end
	end

endmodule

`default_nettype wire
